### rtl/sliding_window_rate_limiter_defines.svh
// assertion macros for the sliding window rate limiter
// used by files that carry concurrent checks; expects clk_i and rst_ni in scope
`ifndef SLIDING_WINDOW_RATE_LIMITER_DEFINES_SVH
`define SLIDING_WINDOW_RATE_LIMITER_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define SWRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property whose consequent must hold in the cycle after its trigger
`define SWRL_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

### rtl/swrl_pkg.sv
// shared types, constants and control store for the sliding window rate limiter
// no dependencies; imported by swrl_seq and sliding_window_rate_limiter
package swrl_pkg;

  // stamp ring geometry
  localparam int unsigned DEPTH = 64;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // field widths
  localparam int unsigned TIME_W = 32;
  localparam int unsigned MAX_W  = 7;
  localparam int unsigned OUT_W  = 40;
  localparam int unsigned ADDR_W = 3;

  // register reset values
  localparam logic [MAX_W-1:0]  MAX_RST    = 7'd10;
  localparam logic [TIME_W-1:0] WINDOW_RST = 32'd1000;

  // register index taken from paddr[2]
  localparam logic REG_MAX    = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  // sequencer step addresses
  localparam int unsigned STEP_W = 2;
  localparam logic [STEP_W-1:0] STEP_FETCH = 2'd0;
  localparam logic [STEP_W-1:0] STEP_TRIM  = 2'd1;
  localparam logic [STEP_W-1:0] STEP_ADMIT = 2'd2;

  // condition that lets a step move on
  typedef enum logic [2:0] {
    COND_IN_VALID = 3'b001,
    COND_NO_POP   = 3'b010,
    COND_OUT_FREE = 3'b100
  } cond_e;

  // one control word
  typedef struct packed {
    logic              accept;  // take an input beat when cond holds
    logic              pop;     // drop the front stamp while cond fails
    logic              grant;   // admit and load the result when cond holds
    cond_e             cond;
    logic [STEP_W-1:0] next;    // step taken once cond holds
  } ucode_t;

  // status from the datapath
  typedef struct packed {
    logic in_valid;
    logic pop_needed;
    logic out_free;
  } seq_status_t;

  // qualified strobes to the datapath
  typedef struct packed {
    logic in_ready;
    logic accept;
    logic pop;
    logic grant;
  } seq_ctrl_t;

  // control store
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    begin
      w = '{accept: 1'b0, pop: 1'b0, grant: 1'b0, cond: COND_IN_VALID, next: STEP_FETCH};
      case (step)
        STEP_FETCH: w = '{accept: 1'b1, pop: 1'b0, grant: 1'b0,
                          cond: COND_IN_VALID, next: STEP_TRIM};
        STEP_TRIM:  w = '{accept: 1'b0, pop: 1'b1, grant: 1'b0,
                          cond: COND_NO_POP, next: STEP_ADMIT};
        STEP_ADMIT: w = '{accept: 1'b0, pop: 1'b0, grant: 1'b1,
                          cond: COND_OUT_FREE, next: STEP_FETCH};
        default:    w = '{accept: 1'b0, pop: 1'b0, grant: 1'b0,
                          cond: COND_IN_VALID, next: STEP_FETCH};
      endcase
      return w;
    end
  endfunction

endpackage

### rtl/swrl_seq.sv
// microcoded sequencer: step counter, control store lookup and branch logic
// depends on swrl_pkg
module swrl_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  swrl_pkg::seq_status_t status_i,
  output swrl_pkg::seq_ctrl_t   ctrl_o
);
  import swrl_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            word;
  logic              cond_ok;

  // fetch the current control word
  assign word = ucode_rom(step_q);

  // evaluate the branch condition
  always_comb begin
    unique case (word.cond)
      COND_IN_VALID: cond_ok = status_i.in_valid;
      COND_NO_POP:   cond_ok = !status_i.pop_needed;
      COND_OUT_FREE: cond_ok = status_i.out_free;
      default:       cond_ok = 1'b0;
    endcase
  end

  // qualified strobes
  assign ctrl_o.in_ready = word.accept;
  assign ctrl_o.accept   = word.accept & cond_ok;
  assign ctrl_o.pop      = word.pop & !cond_ok;
  assign ctrl_o.grant    = word.grant & cond_ok;

  // hold the step until its condition holds, then branch
  assign step_d = cond_ok ? word.next : step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

### rtl/sliding_window_rate_limiter.sv
// Sliding window log rate limiter. Each input beat carries now_time (tdata[31:0]),
// one acquire attempt. Each attempt returns one output beat: granted (tdata[0]),
// remaining allowance (tdata[7:1]) and ticks until the oldest stored stamp
// expires (tdata[39:8]). Limits are set over the APB port: the request limit at
// byte address 0, window_ticks at 4; write them only while no attempt is open.
// An attempt runs through the fetch, trim and admit steps; stale stamps are
// dropped in the trim step, one per cycle through the single read port of the
// 64-entry stamp memory. The admit step then registers the result beat.
// The next input beat can be taken in the cycle after the result is registered,
// while that result may still wait in the output register. If the receiver
// stalls, the sequencer holds in its admit step until the output register
// frees. Reset (rst_ni, asynchronous, active low) empties the stamp log and
// restores the request limit to 10 and window_ticks to 1000; no clearing pass runs.
// depends on swrl_pkg, swrl_seq and sliding_window_rate_limiter_defines.svh
`include "sliding_window_rate_limiter_defines.svh"

module sliding_window_rate_limiter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [swrl_pkg::TIME_W-1:0]   s_axis_tdata,  // [31:0] now_time
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [swrl_pkg::OUT_W-1:0]    m_axis_tdata,  // [0] granted, [7:1] remaining,
                                                       // [39:8] ticks to expiry
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swrl_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import swrl_pkg::*;

  seq_status_t status;
  seq_ctrl_t   ctrl;

  logic [MAX_W-1:0]  max_q;
  logic [TIME_W-1:0] window_q;
  logic [TIME_W-1:0] now_q;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [TIME_W-1:0] ring_mem [DEPTH];
  logic [TIME_W-1:0] rd_data_q;
  logic [PTR_W-1:0]  tail;
  logic              room;
  logic              wr_en;
  logic              cfg_wr;

  logic [TIME_W-1:0] age;
  logic [CNT_W-1:0]  cnt_after;
  logic [TIME_W-1:0] oldest;
  logic [TIME_W-1:0] oldest_age;
  logic [MAX_W-1:0]  remaining;
  logic [TIME_W-1:0] expiry;

  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;

  // sequencer
  swrl_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign status.in_valid   = s_axis_tvalid;
  assign status.pop_needed = (count_q != '0) && (age > window_q);
  assign status.out_free   = !out_valid_q || m_axis_tready;

  assign s_axis_tready = ctrl.in_ready;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= MAX_RST;
      window_q <= WINDOW_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MAX:    max_q    <= pwdata[MAX_W-1:0];
        REG_WINDOW: window_q <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX:    prdata = {{(32-MAX_W){1'b0}}, max_q};
      REG_WINDOW: prdata = window_q;
      default:    prdata = '0;
    endcase
  end

  // latch the attempt time
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      now_q <= s_axis_tdata;
    end
  end

  // age of the front stamp
  assign age = now_q - rd_data_q;

  // admission decision
  assign room  = (count_q < CNT_W'(max_q)) && (count_q < CNT_W'(DEPTH));
  assign wr_en = ctrl.grant & room;
  assign tail  = head_q + count_q[PTR_W-1:0];

  // head and fill count
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctrl.pop) begin
      head_d  = head_q + PTR_W'(1);
      count_d = count_q - CNT_W'(1);
    end else if (wr_en) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // stamp memory, read always at the next front position
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[tail] <= now_q;
    end
    rd_data_q <= ring_mem[head_d];
  end

  // result fields
  assign cnt_after  = count_q + CNT_W'(room);
  assign oldest     = (count_q == '0) ? now_q : rd_data_q;
  assign oldest_age = now_q - oldest;
  assign remaining  = (max_q > cnt_after[MAX_W-1:0]) ? (max_q - cnt_after[MAX_W-1:0]) : '0;

  always_comb begin
    expiry = '0;
    if (cnt_after != '0 && oldest_age < window_q) begin
      expiry = window_q - oldest_age;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.grant) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.grant) begin
      out_data_q <= {expiry, remaining, room};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  `SWRL_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "stamp count above ring depth")
  `SWRL_ASSERT(a_pop_excl, !(ctrl.pop && ctrl.grant), "pop and admit in one cycle")
  `SWRL_ASSERT_NEXT(a_pop_dec, ctrl.pop, count_q == $past(count_q) - CNT_W'(1),
                    "pop did not decrement count")
  `SWRL_ASSERT_NEXT(a_grant_rec, wr_en, count_q != '0 && m_axis_tdata[0],
                    "admitted attempt not recorded")
  `SWRL_ASSERT_NEXT(a_no_drop, out_valid_q && !m_axis_tready && !ctrl.grant,
                    out_valid_q && $stable(out_data_q), "pending result lost")

endmodule

### tb/sv/tb_sliding_window_rate_limiter.sv
// self-checking testbench for the sliding window rate limiter
// depends on swrl_pkg and sliding_window_rate_limiter; a directed table, then random phases
module tb_sliding_window_rate_limiter;
  timeunit 1ns;
  timeprecision 1ps;

  import swrl_pkg::*;

  // one result beat, split into its fields
  typedef struct packed {
    logic              granted;
    logic [MAX_W-1:0]  remaining;
    logic [TIME_W-1:0] until_reset;
  } rl_result_t;

  // directed table rows
  typedef enum logic [1:0] {
    DIR_ATTEMPT,
    DIR_SET_MAX,
    DIR_SET_WINDOW
  } dir_kind_e;

  typedef struct packed {
    dir_kind_e   kind;
    logic [31:0] value;
    logic        has_exp;
    rl_result_t  exp_res;
  } dir_row_t;

  localparam rl_result_t NO_RES = '{1'b0, 7'd0, 32'd0};

  // starts from reset limits: 10 grants per 1000 ticks
  localparam dir_row_t DIR_ROWS [24] = '{
    '{DIR_ATTEMPT,    32'd0,          1'b1, '{1'b1, 7'd9, 32'd1000}},
    '{DIR_ATTEMPT,    32'd0,          1'b0, NO_RES},
    // age equal to the window: kept, expires at this tick
    '{DIR_ATTEMPT,    32'd1000,       1'b0, NO_RES},
    '{DIR_ATTEMPT,    32'd1001,       1'b0, NO_RES},
    // zero limit never grants
    '{DIR_SET_MAX,    32'd0,          1'b0, NO_RES},
    '{DIR_ATTEMPT,    32'd1500,       1'b0, NO_RES},
    '{DIR_ATTEMPT,    32'hFFFF_FFFF,  1'b1, '{1'b0, 7'd0, 32'd0}},
    // zero window keeps only stamps equal to now
    '{DIR_SET_MAX,    32'd64,         1'b0, NO_RES},
    '{DIR_SET_WINDOW, 32'd0,          1'b0, NO_RES},
    '{DIR_ATTEMPT,    32'hFFFF_FFFF,  1'b1, '{1'b1, 7'd63, 32'd0}},
    '{DIR_ATTEMPT,    32'hFFFF_FFFF,  1'b0, NO_RES},
    '{DIR_ATTEMPT,    32'd0,          1'b0, NO_RES},
    // widest window: nothing ever ages out
    '{DIR_SET_WINDOW, 32'hFFFF_FFFF,  1'b0, NO_RES},
    '{DIR_ATTEMPT,    32'h8000_0000,  1'b0, NO_RES},
    '{DIR_ATTEMPT,    32'h7FFF_FFFF,  1'b0, NO_RES},
    // wrapping time around zero with a small limit
    '{DIR_SET_MAX,    32'd3,          1'b0, NO_RES},
    '{DIR_SET_WINDOW, 32'd100,        1'b0, NO_RES},
    '{DIR_ATTEMPT,    32'hFFFF_FFC0,  1'b0, NO_RES},
    '{DIR_ATTEMPT,    32'hFFFF_FFF0,  1'b0, NO_RES},
    '{DIR_ATTEMPT,    32'h0000_0010,  1'b0, NO_RES},
    '{DIR_ATTEMPT,    32'h0000_0011,  1'b0, NO_RES},
    '{DIR_ATTEMPT,    32'h0000_0024,  1'b0, NO_RES},
    '{DIR_ATTEMPT,    32'h0000_0025,  1'b0, NO_RES},
    '{DIR_ATTEMPT,    32'h0000_007F,  1'b0, NO_RES}
  };

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 179;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TIME_W-1:0]  s_axis_tdata;   // [31:0] now_time
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;   // [0] granted, [7:1] remaining, [39:8] ticks to expiry
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // predictor state: granted stamps oldest first, and the limits
  logic [TIME_W-1:0]  stamp_log [$];
  logic [MAX_W-1:0]   lim_max;
  logic [TIME_W-1:0]  lim_window;

  rl_result_t         pending_results [$];
  int                 fail_count;
  int                 tx_idle_pct;
  int                 rx_stall_pct;
  int                 hold_left;

  sliding_window_rate_limiter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // run limit
  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // sliding window log: trim stale stamps, admit, report
  function automatic rl_result_t predict_attempt(input logic [TIME_W-1:0] now);
    rl_result_t        r;
    logic [TIME_W-1:0] age;
    r = NO_RES;
    while (stamp_log.size() > 0 && (now - stamp_log[0]) > lim_window)
      stamp_log.delete(0);
    if (stamp_log.size() < lim_max && stamp_log.size() < DEPTH) begin
      stamp_log.insert(stamp_log.size(), now);
      r.granted = 1'b1;
    end
    if (lim_max > stamp_log.size())
      r.remaining = lim_max - MAX_W'(stamp_log.size());
    if (stamp_log.size() > 0) begin
      age = now - stamp_log[0];
      if (age < lim_window)
        r.until_reset = lim_window - age;
    end
    return r;
  endfunction

  // offer one attempt with random gaps; valid stays high for a following beat
  task automatic send_attempt(input logic [TIME_W-1:0] now, input logic use_typed,
                              input rl_result_t typed_res);
    rl_result_t r;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= now;
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_attempt(now);
    pending_results.insert(pending_results.size(), use_typed ? typed_res : r);
  endtask

  // stop offering and wait until every result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // apb write, setup then access, then read back; block must be idle
  task automatic write_reg(input logic idx, input logic [31:0] val);
    logic [31:0] exp_rd;
    exp_rd  = (idx == REG_MAX) ? {{(32-MAX_W){1'b0}}, val[MAX_W-1:0]} : val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // read back from the same address
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== exp_rd) begin
      $error("prdata: expected %h, got %h", exp_rd, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_MAX)
      lim_max = val[MAX_W-1:0];
    else
      lim_window = val;
    @(posedge clk_i);
  endtask

  // result side: check each beat, then pick next tready
  initial begin
    rl_result_t exp_r;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no attempt pending: %h", m_axis_tdata);
          fail_count++;
        end else begin
          exp_r = pending_results[0];
          pending_results.delete(0);
          if (m_axis_tdata[0] !== exp_r.granted) begin
            $error("granted: expected %0d, got %0d", exp_r.granted, m_axis_tdata[0]);
            fail_count++;
          end
          if (m_axis_tdata[7:1] !== exp_r.remaining) begin
            $error("remaining: expected %0d, got %0d", exp_r.remaining, m_axis_tdata[7:1]);
            fail_count++;
          end
          if (m_axis_tdata[39:8] !== exp_r.until_reset) begin
            $error("until_reset: expected %0d, got %0d",
                   exp_r.until_reset, m_axis_tdata[39:8]);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // main sequence
  initial begin
    logic [TIME_W-1:0] cur_time;
    logic [TIME_W-1:0] now;
    longint            step_max;
    int                pick;
    logic [31:0]       new_max;
    logic [31:0]       new_window;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    fail_count    = 0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_left     = 0;
    lim_max       = MAX_RST;
    lim_window    = WINDOW_RST;
    cur_time      = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (DIR_ROWS[i]) begin
      case (DIR_ROWS[i].kind)
        DIR_ATTEMPT: begin
          send_attempt(DIR_ROWS[i].value, DIR_ROWS[i].has_exp, DIR_ROWS[i].exp_res);
        end
        DIR_SET_MAX: begin
          drain_results();
          write_reg(REG_MAX, DIR_ROWS[i].value);
        end
        default: begin
          drain_results();
          write_reg(REG_WINDOW, DIR_ROWS[i].value);
        end
      endcase
    end

    // random phases, each with its own limits and idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      case (p)
        0: begin new_max = 32'd10; new_window = 32'd1000; end
        1: begin new_max = 32'd64; new_window = 32'hFFFF_FFFF; end
        2: begin new_max = 32'd5;  new_window = 32'd200; end
        3: begin new_max = 32'd1;  new_window = 32'd0; end
        4: begin new_max = $urandom_range(33, 64); new_window = $urandom; end
        5: begin new_max = 32'd0;  new_window = $urandom_range(0, 65535); end
        6: begin new_max = $urandom_range(1, 64); new_window = $urandom_range(1, 50); end
        default: begin new_max = 32'd64; new_window = 32'd5000; end
      endcase
      write_reg(REG_MAX, new_max);
      write_reg(REG_WINDOW, new_window);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
        default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
      endcase
      // long receiver hold-off while attempts keep coming
      if (p == 2)
        hold_left = 400;
      step_max = (longint'(lim_window) * 2) / (longint'(lim_max) + 1) + 1;
      if (step_max > 64'hFFFF_FFFF)
        step_max = 64'hFFFF_FFFF;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // sender pause until all results are back
        if (p == 4 && k == ITEMS_PER_PHASE / 2)
          drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // jump anywhere in time
          cur_time = $urandom;
        end else if (pick < 16) begin
          // same tick again
        end else if (pick < 24 && stamp_log.size() > 0) begin
          // land on the expiry boundary of the oldest stamp
          cur_time = stamp_log[0] + lim_window + TIME_W'($urandom_range(0, 1));
        end else begin
          cur_time = cur_time + TIME_W'($urandom_range(0, 32'(step_max)));
        end
        now = cur_time;
        send_attempt(now, 1'b0, NO_RES);
      end
    end

    // wind down
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/swrl_pkg.sv
rtl/swrl_seq.sv
rtl/sliding_window_rate_limiter.sv
tb/sv/tb_sliding_window_rate_limiter.sv
